>>> design/tx_slot_pending_tracker_core_macros.svh
// Assertion macros for the transmit slot tracker checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TX_SLOT_PENDING_TRACKER_CORE_MACROS_SVH
`define TX_SLOT_PENDING_TRACKER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define TSPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define TSPT_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tspt_pkg.sv
// Package for the transmit slot tracker: payload structs, codes, constants.
// No dependencies.
package tspt_pkg;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] object_number;
        logic [6:0] elapsed_ms;
    } t_cmd;

    typedef struct packed {
        logic        started;
        logic [31:0] pending_mask;
    } t_result;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_DONE = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    localparam logic [6:0] LIMIT_RESET = 7'd50;
    localparam logic       REG_LIMIT   = 1'b0;

endpackage

>>> design/tx_slot_pending_tracker_core.sv
// Transmit slot tracker top level: pending bits in flops, slot timers in a RAM.
// Depends on tspt_pkg.
//
//  channel   direction  handshake                      payload
//  command   in         start && !busy                 i_cmd (t_cmd)
//  result    out        o_done, one cycle              o_result (t_result)
//  config    in         psel&penable&pwrite&pready     pwdata[6:0] @ paddr 0
//
// Send, done and unused codes: result in the cycle after the transfer.
// Tick: walks every slot, one timer RAM read-modify-write per slot per cycle; result registered after the last slot.
// busy is high only during a tick walk; a result never blocks the next command.
// Reset (synchronous) clears pending bits and timer valid bits, limit goes to 50.
// No clearing pass after reset; the receiver cannot stall.
module tx_slot_pending_tracker_core #(
    parameter int SLOT_COUNT = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tspt_pkg::t_cmd   i_cmd,
    output logic             o_done,
    output tspt_pkg::t_result o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tspt_pkg::*;

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_cnt, n_cnt;
    logic [6:0]            r_step, n_step;
    logic [6:0]            r_limit;
    logic [SLOT_COUNT-1:0] r_pending, n_pending;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic                  r_done, n_done;
    logic                  r_started, n_started;
    logic [31:0]           r_mask, n_mask;
    logic [7:0]            r_rdata;
    logic                  r_rd_vld;

    logic [7:0]            mem_timer [SLOT_COUNT];
    logic                  mem_we;
    logic [7:0]            mem_wdata;
    logic [AW-1:0]         rd_addr;

    logic                  accept;
    logic                  in_range;
    logic [AW-1:0]         obj_idx;
    logic [7:0]            cur_timer;

    assign accept   = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign in_range = {1'b0, i_cmd.object_number} < 6'(SLOT_COUNT);
    assign obj_idx  = i_cmd.object_number[AW-1:0];
    assign cur_timer = r_rd_vld ? r_rdata : 8'd0;
    assign rd_addr  = (r_state == ST_WALK && r_cnt != LAST) ? r_cnt + AW'(1) : '0;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_step    = r_step;
        n_pending = r_pending;
        n_valid   = r_valid;
        n_done    = 1'b0;
        n_started = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = cur_timer + 8'(r_step);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_cmd.operation))
                        OP_SEND: begin
                            n_done = 1'b1;
                            if (in_range && !r_pending[obj_idx]) begin
                                n_pending[obj_idx] = 1'b1;
                                n_valid[obj_idx]   = 1'b0;
                                n_started          = 1'b1;
                            end
                        end
                        OP_DONE: begin
                            n_done = 1'b1;
                            if (in_range) begin
                                n_pending[obj_idx] = 1'b0;
                                n_valid[obj_idx]   = 1'b0;
                            end
                        end
                        OP_TICK: begin
                            n_state = ST_WALK;
                            n_cnt   = '0;
                            n_step  = i_cmd.elapsed_ms;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (cur_timer < {1'b0, r_limit}) begin
                    mem_we         = 1'b1;
                    n_valid[r_cnt] = 1'b1;
                end else begin
                    n_pending[r_cnt] = 1'b0;
                end
                if (r_cnt == LAST) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_mask = n_done ? 32'(n_pending) : r_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_pending <= '0;
            r_valid   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_pending <= n_pending;
            r_valid   <= n_valid;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_started <= n_started;
        r_mask    <= n_mask;
        r_rd_vld  <= n_valid[rd_addr];
    end

    // timer RAM, at most one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_timer[r_cnt] <= mem_wdata;
        end
        r_rdata <= mem_timer[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_LIMIT) begin
            r_limit <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIMIT) ? {25'd0, r_limit} : 32'd0;

    assign o_done               = r_done;
    assign o_result.started     = r_started;
    assign o_result.pending_mask = r_mask;

endmodule

>>> design/tspt_checker.sv
// Port-level checker for the transmit slot tracker, bound to the top level.
// Depends on tspt_pkg and tx_slot_pending_tracker_core_macros.svh.
`include "tx_slot_pending_tracker_core_macros.svh"

module tspt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input tspt_pkg::t_cmd    i_cmd,
    input logic              o_done,
    input tspt_pkg::t_result o_result
);
    import tspt_pkg::*;

    logic acc;
    logic acc_tick;
    assign acc      = start && !busy;
    assign acc_tick = acc && (i_cmd.operation == OP_TICK);

    `TSPT_ASSERT_NEXT(a_tick_busy, acc_tick, busy && !o_done, "tick transfer did not start walk")
    `TSPT_ASSERT_NEXT(a_short_result, acc && !acc_tick, o_done && !busy, "missing short result")
    `TSPT_ASSERT_NOW(a_started_src, o_done && o_result.started,
        $past(acc) && $past(i_cmd.operation) == OP_SEND, "started without send transfer")
    `TSPT_ASSERT_NOW(a_started_mask, o_done && o_result.started,
        o_result.pending_mask != 32'd0, "started with empty pending mask")
    `TSPT_ASSERT_RST(a_reset_idle, !i_rst_n, !busy && !o_done, "not idle after reset")

endmodule

bind tx_slot_pending_tracker_core tspt_checker u_tspt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_done   (o_done),
    .o_result (o_result)
);
